>>> rtl/rcdc_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and helper functions for the ring credit
// and doorbell coalescer. No dependencies.
package rcdc_pkg;

    localparam int CNT_W      = 13;
    localparam int OFS_W      = 20;
    localparam int MSG_W      = 8;
    localparam int SHIFT_W    = 5;
    localparam int REQ_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int PROD_W     = CNT_W + MSG_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_INFLIGHT       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REQ_MSG_BYTES      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RESP_MSG_BYTES     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REQ_RING_SHIFT     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RESP_RING_SHIFT    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FORCE_TAIL_LEVEL   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PENDING_TAIL_LEVEL = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_HEAD_WRITE_LEVEL   = 3'd7;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef struct packed {
        logic [CNT_W-1:0]   max_inflight;
        logic [MSG_W-1:0]   req_msg_bytes;
        logic [MSG_W-1:0]   resp_msg_bytes;
        logic [SHIFT_W-1:0] req_ring_shift;
        logic [SHIFT_W-1:0] resp_ring_shift;
        logic [CNT_W-1:0]   force_tail_level;
        logic [CNT_W-1:0]   pending_tail_level;
        logic [CNT_W-1:0]   head_write_level;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_inflight:       13'd4096,
        req_msg_bytes:      8'd128,
        resp_msg_bytes:     8'd32,
        req_ring_shift:     5'd19,
        resp_ring_shift:    5'd17,
        force_tail_level:   13'd32,
        pending_tail_level: 13'd32,
        head_write_level:   13'd32
    };

    typedef struct packed {
        op_t              opcode;
        logic [REQ_W-1:0] requested_count;
        logic [REQ_W-1:0] built_count;
        logic [CNT_W-1:0] responses_ready;
    } item_t;

    // Declared from the highest bit down, so that done_count lands in bit 0.
    typedef struct packed {
        logic [CNT_W-1:0] inflight_now;
        logic [OFS_W-1:0] head_value;
        logic             head_doorbell;
        logic [OFS_W-1:0] tail_value;
        logic             tail_doorbell;
        logic             build_error;
        logic [CNT_W-1:0] done_count;
    } result_t;

    // Byte mask of a power-of-two ring; shifts of 20 and up keep all offset bits.
    function automatic logic [OFS_W-1:0] ring_mask(input logic [SHIFT_W-1:0] shift);
        logic [OFS_W-1:0] m;
        for (int i = 0; i < OFS_W; i++) begin
            m[i] = (shift >= SHIFT_W'(OFS_W)) || (SHIFT_W'(i) < shift);
        end
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/ring_credit_doorbell_coalescer.sv
`timescale 1ns / 1ps
// An accepted item waits in the input register until the output register can
// take its result. Throughput: one item per cycle while m_tready holds nothing
// back; the state update of one item (one multiply by message size, one ring
// add, compares) is combinational. An input register and an output register
// decouple the sides. Reset (aresetn low, synchronous) clears all counters and
// offsets, empties both registers and returns configuration to its defaults.
module ring_credit_doorbell_coalescer #(
    parameter int RING_ENTRIES  = 4096,
    parameter int MAX_MSG_BYTES = 128
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rcdc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rcdc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // requested_count[15:0], built_count[31:16], responses_ready[44:32], zero fill
    input  logic [47:0]                         s_tdata,
    // opcode[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // done_count[12:0], build_error[13], tail_doorbell[14], tail_value[34:15],
    // head_doorbell[35], head_value[55:36], inflight_now[68:56], zero fill
    output logic [71:0]                         m_tdata
);

    localparam int RES_W = $bits(rcdc_pkg::result_t);

    rcdc_pkg::cfg_t    cfg;
    rcdc_pkg::item_t   item_reg;
    rcdc_pkg::item_t   item_next;
    rcdc_pkg::result_t res;
    rcdc_pkg::result_t res_reg;
    logic              in_vld_reg;
    logic              out_vld_reg;
    logic              out_free;
    logic              step_en;
    logic              in_take;

    assign out_free = !out_vld_reg || m_tready;
    assign step_en  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    assign item_next.opcode          = rcdc_pkg::op_t'(s_tuser);
    assign item_next.requested_count = s_tdata[15:0];
    assign item_next.built_count     = s_tdata[31:16];
    assign item_next.responses_ready = s_tdata[44:32];

    rcdc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rcdc_core #(
        .RING_ENTRIES  (RING_ENTRIES),
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_take) begin
                in_vld_reg <= 1'b1;
            end else if (step_en) begin
                in_vld_reg <= 1'b0;
            end
            if (step_en) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            item_reg <= item_next;
        end
        if (step_en) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(72 - RES_W)'(0), res_reg};

endmodule

>>> rtl/rcdc_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the coalescer, written through a plain
// write port. Depends on rcdc_pkg.
module rcdc_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [rcdc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rcdc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output rcdc_pkg::cfg_t                     cfg
);

    rcdc_pkg::cfg_t cfg_reg;
    rcdc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                rcdc_pkg::REG_MAX_INFLIGHT:
                    cfg_next.max_inflight = cfg_wdata;
                rcdc_pkg::REG_REQ_MSG_BYTES:
                    cfg_next.req_msg_bytes = cfg_wdata[rcdc_pkg::MSG_W-1:0];
                rcdc_pkg::REG_RESP_MSG_BYTES:
                    cfg_next.resp_msg_bytes = cfg_wdata[rcdc_pkg::MSG_W-1:0];
                rcdc_pkg::REG_REQ_RING_SHIFT:
                    cfg_next.req_ring_shift = cfg_wdata[rcdc_pkg::SHIFT_W-1:0];
                rcdc_pkg::REG_RESP_RING_SHIFT:
                    cfg_next.resp_ring_shift = cfg_wdata[rcdc_pkg::SHIFT_W-1:0];
                rcdc_pkg::REG_FORCE_TAIL_LEVEL:
                    cfg_next.force_tail_level = cfg_wdata;
                rcdc_pkg::REG_PENDING_TAIL_LEVEL:
                    cfg_next.pending_tail_level = cfg_wdata;
                rcdc_pkg::REG_HEAD_WRITE_LEVEL:
                    cfg_next.head_write_level = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= rcdc_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/rcdc_core.sv
`timescale 1ns / 1ps
// Ring credit and doorbell state with the per-item update logic. One item
// is consumed per enabled cycle. Depends on rcdc_pkg.
module rcdc_core #(
    parameter int RING_ENTRIES  = 4096,
    parameter int MAX_MSG_BYTES = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  rcdc_pkg::item_t   item,
    input  rcdc_pkg::cfg_t    cfg,
    output rcdc_pkg::result_t res
);

    localparam int CW = rcdc_pkg::CNT_W;
    localparam int OW = rcdc_pkg::OFS_W;
    localparam int MW = rcdc_pkg::MSG_W;
    localparam int PW = rcdc_pkg::PROD_W;
    localparam int RW = rcdc_pkg::REQ_W;
    localparam logic [CW-1:0] RING_CAP = CW'(RING_ENTRIES);
    localparam logic [MW-1:0] MSG_CAP  = MW'(MAX_MSG_BYTES);

    logic [CW-1:0] inflight_reg, inflight_next;
    logic [OW-1:0] tail_reg, tail_next;
    logic [OW-1:0] tail_written_reg, tail_written_next;
    logic [CW-1:0] pending_reg, pending_next;
    logic [OW-1:0] head_reg, head_next;
    logic [CW-1:0] processed_reg, processed_next;

    logic          is_enq;
    logic [CW-1:0] limit, room, grant, sent, deq_cnt, mul_cnt;
    logic [MW-1:0] req_msg, resp_size, mul_msg;
    logic [PW-1:0] prod;
    logic [OW-1:0] base, mask, advanced;
    logic [OW:0]   sum;

    assign is_enq    = (item.opcode == rcdc_pkg::OP_ENQUEUE);
    assign limit     = (cfg.max_inflight > RING_CAP) ? RING_CAP : cfg.max_inflight;
    assign room      = limit - inflight_reg;
    assign grant     = (item.requested_count < RW'(room)) ?
                       item.requested_count[CW-1:0] : room;
    assign sent      = (item.built_count < RW'(grant)) ? item.built_count[CW-1:0] : grant;
    assign deq_cnt   = (item.requested_count < RW'(item.responses_ready)) ?
                       item.requested_count[CW-1:0] : item.responses_ready;
    assign req_msg   = (cfg.req_msg_bytes > MSG_CAP) ? MSG_CAP : cfg.req_msg_bytes;
    assign resp_size = (cfg.resp_msg_bytes > MSG_CAP) ? MSG_CAP : cfg.resp_msg_bytes;

    // One multiplier and one ring adder serve both directions.
    assign mul_cnt  = is_enq ? sent : deq_cnt;
    assign mul_msg  = is_enq ? req_msg : resp_size;
    assign prod     = PW'(mul_cnt) * PW'(mul_msg);
    assign base     = is_enq ? tail_reg : head_reg;
    assign mask     = rcdc_pkg::ring_mask(is_enq ? cfg.req_ring_shift : cfg.resp_ring_shift);
    assign sum      = {1'b0, base} + (OW+1)'(prod);
    assign advanced = sum[OW-1:0] & mask;

    always_comb begin
        inflight_next     = inflight_reg;
        tail_next         = tail_reg;
        tail_written_next = tail_written_reg;
        pending_next      = pending_reg;
        head_next         = head_reg;
        processed_next    = processed_reg;
        res               = '0;
        if (is_enq) begin
            if ((item.requested_count != '0) && (inflight_reg < limit)) begin
                res.build_error = (item.built_count < RW'(grant));
                if (sent != '0) begin
                    inflight_next  = inflight_reg + sent;
                    tail_next      = advanced;
                    pending_next   = rcdc_pkg::sat_add(pending_reg, sent);
                    res.done_count = sent;
                    if ((inflight_next < cfg.force_tail_level) ||
                        (pending_next > cfg.pending_tail_level)) begin
                        res.tail_doorbell = 1'b1;
                        res.tail_value    = advanced;
                        pending_next      = '0;
                        tail_written_next = advanced;
                    end
                end
            end
        end else begin
            if (deq_cnt != '0) begin
                head_next      = advanced;
                processed_next = rcdc_pkg::sat_add(processed_reg, deq_cnt);
                inflight_next  = (deq_cnt > inflight_reg) ? '0 : inflight_reg - deq_cnt;
                res.done_count = deq_cnt;
                if (processed_next > cfg.head_write_level) begin
                    res.head_doorbell = 1'b1;
                    res.head_value    = advanced;
                    processed_next    = '0;
                end
            end
            // Flush a tail that was held back once few requests remain.
            if ((inflight_next <= cfg.force_tail_level) && (tail_reg != tail_written_reg)) begin
                res.tail_doorbell = 1'b1;
                res.tail_value    = tail_reg;
                pending_next      = '0;
                tail_written_next = tail_reg;
            end
        end
        res.inflight_now = inflight_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg     <= '0;
            tail_reg         <= '0;
            tail_written_reg <= '0;
            pending_reg      <= '0;
            head_reg         <= '0;
            processed_reg    <= '0;
        end else if (step_en) begin
            inflight_reg     <= inflight_next;
            tail_reg         <= tail_next;
            tail_written_reg <= tail_written_next;
            pending_reg      <= pending_next;
            head_reg         <= head_next;
            processed_reg    <= processed_next;
        end
    end

    a_inflight_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= RING_CAP)
        else $error("in-flight count exceeds ring capacity");

    a_tail_rung_synced: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.tail_doorbell |=> tail_written_reg == tail_reg && pending_reg == '0)
        else $error("tail doorbell did not sync written tail and pending count");

    a_head_rung_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.head_doorbell |=> processed_reg == '0)
        else $error("head doorbell did not clear processed count");

    a_enq_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && is_enq |=> inflight_reg >= $past(inflight_reg))
        else $error("enqueue lowered the in-flight count");

endmodule

>>> tb/rcdc_burst_checker.sv
`timescale 1ns / 1ps
// Checker for the ring credit and doorbell coalescer: predicts the result of every
// accepted burst and compares it with the item on the result channel. Depends on rcdc_pkg.
module rcdc_burst_checker #(
    parameter int RING_ENTRIES  = 4096,
    parameter int MAX_MSG_BYTES = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rcdc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rcdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [47:0]                     s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [71:0]                     m_tdata,
    output int                              mismatches,
    output int                              results_checked,
    output int                              results_owed
);
    import rcdc_pkg::*;

    localparam int unsigned COUNT_CEIL = 8191;

    cfg_t             regs;
    logic [CNT_W-1:0] inflight;
    logic [OFS_W-1:0] req_tail;
    logic [OFS_W-1:0] tail_written;
    logic [CNT_W-1:0] pending;
    logic [OFS_W-1:0] resp_head;
    logic [CNT_W-1:0] processed;
    result_t          burst_outcomes[$];

    initial begin
        mismatches      = 0;
        results_checked = 0;
        results_owed    = 0;
    end

    function automatic int unsigned clip_msg(input logic [MSG_W-1:0] bytes);
        return (bytes > MAX_MSG_BYTES) ? MAX_MSG_BYTES : bytes;
    endfunction

    // Shifts of 20 and above leave the full 20-bit offset.
    function automatic logic [OFS_W-1:0] ring_wrap(input int unsigned ofs,
                                                   input logic [SHIFT_W-1:0] shift);
        if (shift >= OFS_W)
            return ofs[OFS_W-1:0];
        return ofs & ((32'd1 << shift) - 32'd1);
    endfunction

    function automatic logic [CNT_W-1:0] cap_count(input int unsigned sum);
        return (sum > COUNT_CEIL) ? COUNT_CEIL[CNT_W-1:0] : sum[CNT_W-1:0];
    endfunction

    // Applies one burst to the ring state and returns the result it produces.
    function automatic result_t coalesce_burst(input op_t op, input logic [15:0] asked,
                                               input logic [15:0] built,
                                               input logic [12:0] ready);
        result_t     r;
        int unsigned limit;
        int unsigned room;
        int unsigned grant;
        int unsigned sent;
        int unsigned cnt;
        bit          ring_tail;
        r = '0;
        ring_tail = 1'b0;
        if (op == OP_ENQUEUE) begin
            limit = (regs.max_inflight > RING_ENTRIES) ? RING_ENTRIES : regs.max_inflight;
            if (asked != 0 && inflight < limit) begin
                room  = limit - inflight;
                grant = (asked < room) ? asked : room;
                sent  = (built < grant) ? built : grant;
                r.build_error = (built < grant);
                if (sent != 0) begin
                    inflight  = inflight + sent;
                    req_tail  = ring_wrap(req_tail + sent * clip_msg(regs.req_msg_bytes),
                                          regs.req_ring_shift);
                    pending   = cap_count(pending + sent);
                    r.done_count = sent;
                    ring_tail = (inflight < regs.force_tail_level) ||
                                (pending > regs.pending_tail_level);
                end
            end
        end else begin
            cnt = (ready < asked) ? ready : asked;
            if (cnt != 0) begin
                resp_head = ring_wrap(resp_head + cnt * clip_msg(regs.resp_msg_bytes),
                                      regs.resp_ring_shift);
                processed = cap_count(processed + cnt);
                inflight  = (cnt > inflight) ? '0 : inflight - cnt;
                r.done_count = cnt;
                if (processed > regs.head_write_level) begin
                    r.head_doorbell = 1'b1;
                    r.head_value    = resp_head;
                    processed       = '0;
                end
            end
            // A dequeue flushes an unwritten tail once few requests remain in flight.
            ring_tail = (inflight <= regs.force_tail_level) && (req_tail != tail_written);
        end
        if (ring_tail) begin
            r.tail_doorbell = 1'b1;
            r.tail_value    = req_tail;
            pending         = '0;
            tail_written    = req_tail;
        end
        r.inflight_now = inflight;
        return r;
    endfunction

    function automatic string describe(input result_t r);
        return $sformatf("done=%0d berr=%0d tail=%0d/%05h head=%0d/%05h inflight=%0d",
                         r.done_count, r.build_error, r.tail_doorbell, r.tail_value,
                         r.head_doorbell, r.head_value, r.inflight_now);
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            regs         = CFG_RESET;
            inflight     = '0;
            req_tail     = '0;
            tail_written = '0;
            pending      = '0;
            resp_head    = '0;
            processed    = '0;
            burst_outcomes.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MAX_INFLIGHT:       regs.max_inflight       = cfg_wdata;
                    REG_REQ_MSG_BYTES:      regs.req_msg_bytes      = cfg_wdata[MSG_W-1:0];
                    REG_RESP_MSG_BYTES:     regs.resp_msg_bytes     = cfg_wdata[MSG_W-1:0];
                    REG_REQ_RING_SHIFT:     regs.req_ring_shift     = cfg_wdata[SHIFT_W-1:0];
                    REG_RESP_RING_SHIFT:    regs.resp_ring_shift    = cfg_wdata[SHIFT_W-1:0];
                    REG_FORCE_TAIL_LEVEL:   regs.force_tail_level   = cfg_wdata;
                    REG_PENDING_TAIL_LEVEL: regs.pending_tail_level = cfg_wdata;
                    REG_HEAD_WRITE_LEVEL:   regs.head_write_level   = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[68:0]);
                if (burst_outcomes.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing outstanding: %s",
                                 $realtime, describe(got));
                    mismatches++;
                end else begin
                    want = burst_outcomes.pop_front();
                    if (got.done_count !== want.done_count ||
                        got.build_error !== want.build_error ||
                        got.tail_doorbell !== want.tail_doorbell ||
                        got.tail_value !== want.tail_value ||
                        got.head_doorbell !== want.head_doorbell ||
                        got.head_value !== want.head_value ||
                        got.inflight_now !== want.inflight_now) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $realtime, describe(want), describe(got));
                        mismatches++;
                    end
                end
                results_checked++;
            end
            if (s_tvalid && s_tready)
                burst_outcomes.push_back(coalesce_burst(op_t'(s_tuser), s_tdata[15:0],
                                                        s_tdata[31:16], s_tdata[44:32]));
        end
        results_owed = burst_outcomes.size();
    end

endmodule

>>> tb/tb_ring_credit_doorbell_coalescer.sv
`timescale 1ns / 1ps
// Testbench top for the ring credit and doorbell coalescer: drives directed and random
// bursts and register settings, and gives the verdict. Depends on rcdc_pkg and the checker.
module tb_ring_credit_doorbell_coalescer;
    import rcdc_pkg::*;

    localparam int RING_ENTRIES  = 4096;
    localparam int MAX_MSG_BYTES = 128;
    localparam int CHOKE_CYCLES  = 200;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [71:0]           m_tdata;

    int mismatches;
    int results_checked;
    int results_owed;
    int bursts_sent = 0;
    bit jitter      = 1'b0;
    bit choke_done  = 1'b0;

    ring_credit_doorbell_coalescer #(
        .RING_ENTRIES  (RING_ENTRIES),
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rcdc_burst_checker #(
        .RING_ENTRIES  (RING_ENTRIES),
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .results_checked (results_checked),
        .results_owed    (results_owed)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: short random stalls, plus one long hold that backs up the input.
    initial begin : result_sink
        int gap;
        forever begin
            @(posedge aclk);
            if (!choke_done && bursts_sent >= 400) begin
                choke_done = 1'b1;
                m_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (jitter && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_burst(input op_t op, input logic [15:0] asked,
                              input logic [15:0] built, input logic [12:0] ready);
        int gap;
        if (jitter && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, ready, built, asked};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bursts_sent++;
    endtask

    // Waits until every accepted item has produced its result.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_checked != bursts_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic program_regs(input cfg_t c);
        put_reg(REG_MAX_INFLIGHT,       c.max_inflight);
        put_reg(REG_REQ_MSG_BYTES,      CFG_DATA_W'(c.req_msg_bytes));
        put_reg(REG_RESP_MSG_BYTES,     CFG_DATA_W'(c.resp_msg_bytes));
        put_reg(REG_REQ_RING_SHIFT,     CFG_DATA_W'(c.req_ring_shift));
        put_reg(REG_RESP_RING_SHIFT,    CFG_DATA_W'(c.resp_ring_shift));
        put_reg(REG_FORCE_TAIL_LEVEL,   c.force_tail_level);
        put_reg(REG_PENDING_TAIL_LEVEL, c.pending_tail_level);
        put_reg(REG_HEAD_WRITE_LEVEL,   c.head_write_level);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 13'd4096;
            2:       return 13'd8191;
            3:       return $urandom_range(0, 64);
            default: return $urandom_range(0, 4096);
        endcase
    endfunction

    function automatic cfg_t random_setup();
        cfg_t c;
        c.max_inflight       = ($urandom_range(0, 3) == 0) ? 13'd2 : pick_level();
        c.req_msg_bytes      = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(1, 128);
        c.resp_msg_bytes     = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(1, 128);
        c.req_ring_shift     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(7, 20);
        c.resp_ring_shift    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(7, 20);
        c.force_tail_level   = pick_level();
        c.pending_tail_level = pick_level();
        c.head_write_level   = pick_level();
        return c;
    endfunction

    // Mostly sensible bursts of modest size, with some build failures and full-range noise.
    task automatic random_burst();
        op_t         op;
        logic [15:0] asked;
        logic [15:0] built;
        logic [12:0] ready;
        int          pick;
        op   = ($urandom_range(0, 1) == 0) ? OP_ENQUEUE : OP_DEQUEUE;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            asked = $urandom;
            built = $urandom;
            ready = $urandom;
        end else begin
            asked = $urandom_range(1, (pick < 4) ? 600 : 48);
            case ($urandom_range(0, 9))
                0:       built = $urandom_range(0, asked);
                1:       built = $urandom_range(asked, 65535);
                default: built = asked;
            endcase
            ready = $urandom_range(0, 2 * asked);
        end
        push_burst(op, asked, built, ready);
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: empty enqueue, full ring of credit, oversized dequeue.
        push_burst(OP_ENQUEUE, 16'd0, 16'd0, 13'd0);
        push_burst(OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 13'h1FFF);
        push_burst(OP_DEQUEUE, 16'hFFFF, 16'h0000, 13'h1FFF);

        // Tiny credit, oversized messages, tail offset wrapping at 20 bits.
        settle();
        program_regs('{max_inflight: 13'd3, req_msg_bytes: 8'd200, resp_msg_bytes: 8'd255,
                       req_ring_shift: 5'd31, resp_ring_shift: 5'd7,
                       force_tail_level: 13'd1, pending_tail_level: 13'd2,
                       head_write_level: 13'd1});
        push_burst(OP_ENQUEUE, 16'd0, 16'd0, 13'd0);
        push_burst(OP_ENQUEUE, 16'd5, 16'd0, 13'd0);
        push_burst(OP_ENQUEUE, 16'd2, 16'd1, 13'd0);
        push_burst(OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 13'd0);
        push_burst(OP_ENQUEUE, 16'd1, 16'd1, 13'd0);
        push_burst(OP_DEQUEUE, 16'hFFFF, 16'd0, 13'd0);
        push_burst(OP_DEQUEUE, 16'd1, 16'd0, 13'h1FFF);
        push_burst(OP_DEQUEUE, 16'hFFFF, 16'hFFFF, 13'h1FFF);
        push_burst(OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 13'd0);
        push_burst(OP_DEQUEUE, 16'd2, 16'd0, 13'd2);

        // Limit above the ring size and doorbells held back so the counters saturate.
        settle();
        program_regs('{max_inflight: 13'd8191, req_msg_bytes: 8'd1, resp_msg_bytes: 8'd128,
                       req_ring_shift: 5'd20, resp_ring_shift: 5'd20,
                       force_tail_level: 13'd0, pending_tail_level: 13'd8191,
                       head_write_level: 13'd8191});
        push_burst(OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 13'd0);
        push_burst(OP_DEQUEUE, 16'd1, 16'd0, 13'd1);
        push_burst(OP_ENQUEUE, 16'd1, 16'd1, 13'd0);
        push_burst(OP_DEQUEUE, 16'd4095, 16'd0, 13'd4095);
        push_burst(OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 13'd0);
        push_burst(OP_DEQUEUE, 16'hFFFF, 16'd0, 13'h1FFF);

        for (int ph = 0; ph < 7; ph++) begin
            settle();
            jitter = (ph != 6) && ($urandom_range(0, 3) != 0);
            program_regs(random_setup());
            for (int n = 0; n < 250; n++)
                random_burst();
        end

        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && results_owed == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
